@@ hw/rtl/modbus_coil_server_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the coil server core
// Concurrent checks sampled on clk and disabled while rst_n is low.
// Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef MODBUS_COIL_SERVER_CORE_MACROS_SVH
`define MODBUS_COIL_SERVER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// The condition must hold at every sampled edge.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, codes and sizing constants for the coil server core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

    // Coil store sizing. The store is kept as rows of eight coils.
    localparam int COIL_COUNT     = 256;
    localparam int ROW_BITS       = 8;
    localparam int ROW_COUNT      = COIL_COUNT / ROW_BITS;
    localparam int ROW_AW         = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROW_CW         = ROW_AW + 1;

    // A read gives at most 32 data bytes.
    localparam int MAX_READ_COILS = 256;
    localparam int QTY_W          = $clog2(MAX_READ_COILS + 1);
    localparam int NBYTE_W        = 6;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Request operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_READ_DATA  = 2'd0;
    localparam logic [1:0] ST_WRITE_DONE = 2'd1;
    localparam logic [1:0] ST_FAILED     = 2'd2;

    // Response function codes.
    localparam logic [2:0] FC_NONE  = 3'd0;
    localparam logic [2:0] FC_READ  = 3'd1;
    localparam logic [2:0] FC_WRITE = 3'd5;

    // Fixed header lengths.
    localparam logic [15:0] FAIL_LENGTH      = 16'd2;
    localparam logic [15:0] READ_LENGTH_BASE = 16'd3;

    // High byte of a write value that switches a coil on.
    localparam logic [7:0] COIL_ON_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_FAIL
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WR_RD,
        BK_WR_WB,
        BK_RESP,
        BK_RD_PRIME,
        BK_RD_FETCH,
        BK_RD_EMIT
    } back_state_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] transaction_id;
        logic [7:0]  unit_id;
        logic [15:0] request_length;
        logic [15:0] coil_address;
        logic [15:0] coil_quantity;
        logic [15:0] coil_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] echo_transaction;
        logic [7:0]  echo_unit;
        logic [2:0]  function_code;
        logic [15:0] frame_length;
        logic [5:0]  byte_total;
        logic [7:0]  coil_byte;
        logic [15:0] echo_address;
        logic [15:0] echo_value;
        logic        last;
    } rsp_t;

    // Classified request as it travels from the front to the back end.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [15:0]        transaction_id;
        logic [7:0]         unit_id;
        logic [15:0]        request_length;
        logic [15:0]        coil_address;
        logic [15:0]        coil_value;
        logic               in_range;
        logic [QTY_W-1:0]   quantity;
        logic [NBYTE_W-1:0] data_bytes;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/modbus_coil_server_core.sv @@
// ---------------------------------------------------------------------------
// modbus_coil_server_core: write-single-coil / read-coils server
// The back-end sequencer finishes each command before it takes the next one.
// Reset: rst_n clears control state and marks every coil row off; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_coil_server_core_macros.svh"

// The core is split into three parts. The front end classifies each request
// beat as it arrives: it checks the start address, the quantity and the end
// of the range against the store size and works out the number of data
// bytes a read returns. The classified command goes into a two-entry queue,
// so a new request can be taken while the back end is still busy.
//
// The back end is a sequencer over the coil store, which is held as rows of
// eight coils in a RAM with a registered read. A per-row valid bit, cleared
// by reset, makes a row that was never written read as all coils off. A
// write does a read-modify-write of one row. A read walks consecutive rows
// and forms each data byte from the current and the previous row, shifted
// by the bit offset of the start address and masked past the last coil, so
// a read streams one byte per cycle while the response side takes them.
//
// Results leave through a response register, so the sequencer keeps working
// while a finished beat waits for rsp_ready.

module modbus_coil_server_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mcs_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mcs_pkg::rsp_t      rsp
);
    import mcs_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // Beat classes and header terms used by the checks below.
    logic read_beat;
    logic other_beat;
    logic read_len_ok;
    logic no_data;

    mcs_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    mcs_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign read_beat   = rsp_valid && (rsp.status == ST_READ_DATA);
    assign other_beat  = rsp_valid && (rsp.status != ST_READ_DATA);
    assign read_len_ok = (rsp.frame_length == READ_LENGTH_BASE + 16'(rsp.byte_total))
                      && (rsp.byte_total != 6'd0);
    assign no_data     = (rsp.byte_total == 6'd0) && (rsp.coil_byte == 8'd0);

    // A failure or write response is always the only beat of its request.
    `ASSERT_IMPL(a_single_beat_last, other_beat, rsp.last)

    // Read data beats carry a consistent header length and a nonzero count.
    `ASSERT_IMPL(a_read_length, read_beat, read_len_ok)

    // Only read beats carry coil data.
    `ASSERT_IMPL(a_no_data_outside_read, other_beat, no_data)

    // The front end never offers a command the queue cannot take while
    // accepting a request.
    `ASSERT_ALWAYS(a_accept_has_room, !(req_valid && req_ready) || push_ready)

endmodule

`default_nettype wire

@@ hw/rtl/mcs_ram.sv @@
// ----------------------------------------------------------------------------
// mcs_ram
// Generic single-port RAM with a registered read that holds between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcs_front.sv @@
// ----------------------------------------------------------------------------
// mcs_front
// Request classifier: range checks, byte count and command build.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_front (
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mcs_pkg::req_t req,
    output logic               push_valid,
    input  wire logic          push_ready,
    output mcs_pkg::cmd_t      push_cmd
);
    import mcs_pkg::*;

    logic [16:0] addr_ext;
    logic [16:0] qty_ext;
    logic [16:0] end_ext;
    logic [16:0] qty_round;
    logic        addr_ok;
    logic        read_bad;

    assign req_ready  = push_ready;
    assign push_valid = req_valid;

    always_comb
    begin
        addr_ext  = {1'b0, req.coil_address};
        qty_ext   = {1'b0, req.coil_quantity};
        end_ext   = addr_ext + qty_ext;
        qty_round = qty_ext + 17'd7;

        addr_ok  = addr_ext < 17'(COIL_COUNT);
        read_bad = !addr_ok
                || (req.coil_quantity == 16'd0)
                || (qty_ext > 17'(MAX_READ_COILS))
                || (end_ext > 17'(COIL_COUNT));

        push_cmd.transaction_id = req.transaction_id;
        push_cmd.unit_id        = req.unit_id;
        push_cmd.request_length = req.request_length;
        push_cmd.coil_address   = req.coil_address;
        push_cmd.coil_value     = req.coil_value;
        push_cmd.in_range       = addr_ok;
        push_cmd.quantity       = QTY_W'(req.coil_quantity);
        push_cmd.data_bytes     = NBYTE_W'(qty_round >> 3);

        if (req.operation == OP_WRITE)
        begin
            push_cmd.kind = CMD_WRITE;
        end
        else if (read_bad)
        begin
            push_cmd.kind = CMD_FAIL;
        end
        else
        begin
            push_cmd.kind = CMD_READ;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcs_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// mcs_cmd_queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire mcs_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output mcs_pkg::cmd_t      pop_cmd
);
    import mcs_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcs_back.sv @@
// ----------------------------------------------------------------------------
// mcs_back
// Command sequencer: coil store access, byte packing and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire mcs_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mcs_pkg::rsp_t      rsp
);
    import mcs_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cur_reg;
    cmd_t                 cur_next;
    logic [ROW_CW-1:0]    row_reg;
    logic [ROW_CW-1:0]    row_next;
    logic [QTY_W-1:0]     rem_reg;
    logic [QTY_W-1:0]     rem_next;
    logic [ROW_BITS-1:0]  prev_reg;
    logic [ROW_BITS-1:0]  prev_next;
    logic                 rd_ok_reg;
    logic                 rd_ok_next;
    logic [ROW_COUNT-1:0] row_valid_reg;
    logic [ROW_COUNT-1:0] row_valid_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [ROW_AW-1:0]    ram_addr;
    logic [ROW_BITS-1:0]  ram_wdata;
    logic [ROW_BITS-1:0]  ram_rdata;

    logic                 rsp_free;
    logic                 row_in_range;
    logic [ROW_BITS-1:0]  row_data;
    logic [15:0]          window;
    logic [ROW_BITS-1:0]  byte_mask;
    logic [ROW_BITS-1:0]  packed_byte;
    logic                 last_byte;
    logic                 issue;
    logic [ROW_CW-1:0]    cmd_row;
    logic [15:0]          addr_shift;
    logic                 coil_on;

    mcs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROW_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Datapath terms shared by the control blocks.
    always_comb
    begin
        addr_shift   = cmd.coil_address >> 3;
        cmd_row      = ROW_CW'(addr_shift);
        row_in_range = row_reg < ROW_CW'(ROW_COUNT);
        row_data     = rd_ok_reg ? ram_rdata : '0;
        window       = {row_data, prev_reg} >> cur_reg.coil_address[2:0];
        byte_mask    = (rem_reg >= QTY_W'(ROW_BITS)) ? '1
                                                     : ~(8'hFF << rem_reg[2:0]);
        packed_byte  = window[7:0] & byte_mask;
        last_byte    = rem_reg <= QTY_W'(ROW_BITS);
        coil_on      = cur_reg.coil_value[15:8] == COIL_ON_BYTE;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_WRITE: state_next = BK_WR_RD;
                        CMD_READ:  state_next = BK_RD_PRIME;
                        default:   state_next = BK_RESP;
                    endcase
                end
            end
            BK_WR_RD:    state_next = BK_WR_WB;
            BK_WR_WB:    state_next = BK_RESP;
            BK_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_RD_PRIME: state_next = BK_RD_FETCH;
            BK_RD_FETCH: state_next = BK_RD_EMIT;
            BK_RD_EMIT:
            begin
                if (rsp_free && last_byte)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        cmd_ready      = 1'b0;
        cur_next       = cur_reg;
        row_next       = row_reg;
        rem_next       = rem_reg;
        prev_next      = prev_reg;
        row_valid_next = row_valid_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        issue          = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = row_data;

        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next = cmd;
                    row_next = cmd_row;
                    rem_next = cmd.quantity;
                end
            end
            BK_WR_RD:
            begin
                issue = 1'b1;
            end
            BK_WR_WB:
            begin
                ram_wdata = row_data;
                ram_wdata[cur_reg.coil_address[2:0]] = coil_on;
                if (cur_reg.in_range)
                begin
                    ram_we = 1'b1;
                    row_valid_next[row_reg[ROW_AW-1:0]] = 1'b1;
                end
            end
            BK_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.echo_transaction = cur_reg.transaction_id;
                    rsp_next.echo_unit        = cur_reg.unit_id;
                    rsp_next.byte_total       = '0;
                    rsp_next.coil_byte        = '0;
                    rsp_next.last             = 1'b1;
                    if (cur_reg.kind == CMD_WRITE)
                    begin
                        rsp_next.status        = ST_WRITE_DONE;
                        rsp_next.function_code = FC_WRITE;
                        rsp_next.frame_length  = cur_reg.request_length;
                        rsp_next.echo_address  = cur_reg.coil_address;
                        rsp_next.echo_value    = cur_reg.coil_value;
                    end
                    else
                    begin
                        rsp_next.status        = ST_FAILED;
                        rsp_next.function_code = FC_NONE;
                        rsp_next.frame_length  = FAIL_LENGTH;
                        rsp_next.echo_address  = '0;
                        rsp_next.echo_value    = '0;
                    end
                end
            end
            BK_RD_PRIME:
            begin
                issue    = 1'b1;
                row_next = row_reg + 1'b1;
            end
            BK_RD_FETCH:
            begin
                prev_next = row_data;
                issue     = 1'b1;
                row_next  = row_reg + 1'b1;
            end
            BK_RD_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = ST_READ_DATA;
                    rsp_next.echo_transaction = cur_reg.transaction_id;
                    rsp_next.echo_unit        = cur_reg.unit_id;
                    rsp_next.function_code    = FC_READ;
                    rsp_next.frame_length     = READ_LENGTH_BASE
                                              + 16'(cur_reg.data_bytes);
                    rsp_next.byte_total       = cur_reg.data_bytes;
                    rsp_next.coil_byte        = packed_byte;
                    rsp_next.echo_address     = '0;
                    rsp_next.echo_value       = '0;
                    rsp_next.last             = last_byte;
                    prev_next                 = row_data;
                    if (!last_byte)
                    begin
                        rem_next = rem_reg - QTY_W'(ROW_BITS);
                        issue    = 1'b1;
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase

        // A row past the end of the store reads as all coils off.
        ram_re     = issue && row_in_range;
        ram_addr   = row_reg[ROW_AW-1:0];
        rd_ok_next = issue ? (row_in_range && row_valid_reg[row_reg[ROW_AW-1:0]])
                           : rd_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            row_valid_reg <= row_valid_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        row_reg  <= row_next;
        rem_reg  <= rem_next;
        prev_reg <= prev_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

@@ sim/modbus_coil_server_core_tb.sv @@
// ----------------------------------------------------------------------------
// modbus_coil_server_core_tb
// Self-checking testbench for the coil server core. A directed set of
// requests covers the edges of the coil store and every failure rule. Random
// requests follow, mostly well-formed reads and writes with some noise. Each
// accepted request is run through a behavioral coil store, and every response
// beat is compared field by field, in order, with the predicted beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mcs_pkg::*;

// Keeps a shadow copy of the coil store and the queue of response beats that
// the accepted requests should produce.
class coil_scoreboard;
    logic [COIL_COUNT-1:0] coils;
    rsp_t                  awaited[$];
    int                    failures;
    int                    beats_seen;
    int                    writes_sent;
    int                    reads_served;
    int                    reads_failed;

    function new();
        coils        = '0;
        failures     = 0;
        beats_seen   = 0;
        writes_sent  = 0;
        reads_served = 0;
        reads_failed = 0;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Works out the beats that one accepted request gives and updates the
    // shadow store for a write.
    function void note_request(req_t r);
        int unsigned first;
        int unsigned count;
        int unsigned nbytes;
        rsp_t        beat;

        first = r.coil_address;
        count = r.coil_quantity;
        beat  = '0;
        beat.echo_transaction = r.transaction_id;
        beat.echo_unit        = r.unit_id;
        beat.last             = 1'b1;

        if (r.operation == OP_WRITE)
        begin
            writes_sent++;
            // An address past the store still gets the normal echo.
            if (first < COIL_COUNT)
                coils[first] = (r.coil_value[15:8] == COIL_ON_BYTE);
            beat.status        = ST_WRITE_DONE;
            beat.function_code = FC_WRITE;
            beat.frame_length  = r.request_length;
            beat.echo_address  = r.coil_address;
            beat.echo_value    = r.coil_value;
            awaited.push_back(beat);
        end
        else if (first >= COIL_COUNT || count == 0 || count > MAX_READ_COILS ||
                 first + count > COIL_COUNT)
        begin
            reads_failed++;
            beat.status        = ST_FAILED;
            beat.function_code = FC_NONE;
            beat.frame_length  = FAIL_LENGTH;
            awaited.push_back(beat);
        end
        else
        begin
            reads_served++;
            nbytes             = (count + 7) / 8;
            beat.status        = ST_READ_DATA;
            beat.function_code = FC_READ;
            beat.frame_length  = READ_LENGTH_BASE + 16'(nbytes);
            beat.byte_total    = 6'(nbytes);
            for (int k = 0; k < nbytes; k++)
            begin
                beat.coil_byte = '0;
                for (int b = 0; b < 8; b++)
                    if (k * 8 + b < count)
                        beat.coil_byte[b] = coils[first + k * 8 + b];
                beat.last = (k + 1 == nbytes);
                awaited.push_back(beat);
            end
        end
    endfunction

    function string field_diff(string name, int unsigned want, int unsigned got);
        if (want == got)
            return "";
        return $sformatf(" %s exp=%0h got=%0h", name, want, got);
    endfunction

    // Compares one accepted response beat with the oldest prediction.
    function void check_beat(rsp_t got);
        rsp_t  want;
        string diff;

        beats_seen++;
        if (awaited.size() == 0)
        begin
            flag($sformatf("response beat %0d with nothing pending: %h", beats_seen, got));
            return;
        end
        want = awaited.pop_front();
        if ($isunknown(got))
        begin
            flag($sformatf("beat %0d has unknown bits: exp %h got %h",
                           beats_seen, want, got));
            return;
        end
        diff = {field_diff("status", want.status, got.status),
                field_diff("echo_transaction", want.echo_transaction, got.echo_transaction),
                field_diff("echo_unit", want.echo_unit, got.echo_unit),
                field_diff("function_code", want.function_code, got.function_code),
                field_diff("frame_length", want.frame_length, got.frame_length),
                field_diff("byte_total", want.byte_total, got.byte_total),
                field_diff("coil_byte", want.coil_byte, got.coil_byte),
                field_diff("echo_address", want.echo_address, got.echo_address),
                field_diff("echo_value", want.echo_value, got.echo_value),
                field_diff("last", want.last, got.last)};
        if (diff != "")
            flag($sformatf("beat %0d mismatch:%s", beats_seen, diff));
    endfunction
endclass

module modbus_coil_server_core_tb;

    // Longest run of cycles with no beat on either channel before the run
    // is declared hung. A correct run never comes near it.
    localparam int HANG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 80;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // While set, neither side inserts idle cycles.
    logic calm;
    int   quiet_cycles;

    coil_scoreboard sb = new();

    modbus_coil_server_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Response side: random back-pressure, beat checking and the hang
    // watchdog. All signals here are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        if (calm)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(99) >= 8);

        if (rst_n && rsp_valid && rsp_ready)
            sb.check_beat(rsp);

        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("ERROR: no beat moved for %0d cycles, %0d beats pending",
                     HANG_LIMIT, sb.awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Builds a request with random identifiers and header length.
    function automatic req_t make_req(logic op, int unsigned addr, int unsigned qty,
                                      int unsigned value);
        req_t r;
        r.operation      = op;
        r.transaction_id = 16'($urandom);
        r.unit_id        = 8'($urandom);
        r.request_length = 16'($urandom);
        r.coil_address   = 16'(addr);
        r.coil_quantity  = 16'(qty);
        r.coil_value     = 16'(value);
        return r;
    endfunction

    // Presents one request beat, with an optional random gap in front of it,
    // and holds it until the core accepts it.
    task automatic send_request(input req_t r);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 8)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic send_random_write();
        int unsigned addr;
        int unsigned value;
        int unsigned pick;
        // Writes cluster in the low coils so that reads find them again.
        pick = $urandom_range(99);
        if (pick < 50)
            addr = $urandom_range(63);
        else if (pick < 92)
            addr = $urandom_range(COIL_COUNT - 1);
        else
            addr = $urandom_range(16'hFFFF);
        pick = $urandom_range(99);
        if (pick < 50)
            value = {8'hFF, 8'($urandom)};
        else if (pick < 90)
            value = $urandom_range(16'hFFFF);
        else
            value = 0;
        send_request(make_req(OP_WRITE, addr, $urandom_range(16'hFFFF), value));
    endtask

    task automatic send_random_read();
        int unsigned addr;
        int unsigned qty;
        int unsigned room;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            // Well-formed read, usually short, now and then up to the end
            // of the store.
            addr = ($urandom_range(1) == 0) ? $urandom_range(63)
                                            : $urandom_range(COIL_COUNT - 1);
            room = COIL_COUNT - addr;
            if ($urandom_range(99) < 80)
                qty = $urandom_range((room < 24) ? room : 24, 1);
            else
                qty = $urandom_range(room, 1);
        end
        else
        begin
            // Requests that break one of the range rules.
            case ($urandom_range(3))
                0:
                begin
                    addr = $urandom_range(16'hFFFF);
                    qty  = $urandom_range(16'hFFFF);
                end
                1:
                begin
                    addr = $urandom_range(COIL_COUNT - 1);
                    qty  = 0;
                end
                2:
                begin
                    addr = $urandom_range(COIL_COUNT - 1, 1);
                    qty  = COIL_COUNT - addr + $urandom_range(8, 1);
                end
                default:
                begin
                    addr = $urandom_range(16'hFFFF, COIL_COUNT);
                    qty  = $urandom_range(32, 1);
                end
            endcase
        end
        send_request(make_req(OP_READ, addr, qty, $urandom_range(16'hFFFF)));
    endtask

    initial
    begin
        req_t r;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        calm      <= 1'b0;
        quiet_cycles <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A read straight after reset sees every coil off.
        r = make_req(OP_READ, 0, 8, 0);
        r.transaction_id = '0;
        r.unit_id        = '0;
        r.request_length = '0;
        send_request(r);
        send_request(make_req(OP_WRITE, 0, 0, 16'hFF00));
        send_request(make_req(OP_WRITE, 3, 16'hFFFF, 16'hFFFF));
        send_request(make_req(OP_WRITE, COIL_COUNT - 1, 5, 16'hFF00));
        // Only a high byte of all ones switches a coil on.
        send_request(make_req(OP_WRITE, 7, 1, 16'h00FF));
        send_request(make_req(OP_WRITE, 8, 0, 16'hFF12));
        send_request(make_req(OP_WRITE, 9, 0, 16'hFE00));
        // A write past the store leaves it alone but is still echoed.
        r = make_req(OP_WRITE, COIL_COUNT, 16'hFFFF, 16'hFF00);
        r.transaction_id = 16'hFFFF;
        r.unit_id        = 8'hFF;
        r.request_length = 16'hFFFF;
        send_request(r);
        send_request(make_req(OP_WRITE, 16'hFFFF, 0, 16'hFFFF));
        send_request(make_req(OP_READ, 0, 1, 16'hFFFF));
        send_request(make_req(OP_READ, 0, MAX_READ_COILS, 0));
        send_request(make_req(OP_READ, 3, 13, 0));
        send_request(make_req(OP_READ, COIL_COUNT - 1, 1, 0));
        send_request(make_req(OP_READ, COIL_COUNT - 6, 6, 0));
        send_request(make_req(OP_READ, COIL_COUNT - 8, 8, 0));
        // Range past the end, start out of range, zero and oversized reads.
        send_request(make_req(OP_READ, COIL_COUNT - 6, 7, 0));
        send_request(make_req(OP_READ, COIL_COUNT, 1, 0));
        send_request(make_req(OP_READ, 16'hFFFF, 16'hFFFF, 0));
        send_request(make_req(OP_READ, 10, 0, 0));
        send_request(make_req(OP_READ, 0, MAX_READ_COILS + 1, 0));
        send_request(make_req(OP_READ, 1, MAX_READ_COILS, 0));
        send_request(make_req(OP_WRITE, COIL_COUNT - 1, 0, 16'h0000));
        send_request(make_req(OP_READ, COIL_COUNT - 8, 8, 0));

        // Random part, with one stretch in the middle where neither side
        // idles so the core runs at full rate.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm <= (i >= 40 && i < 70);
            if ($urandom_range(99) < 40)
                send_random_write();
            else
                send_random_read();
        end
        req_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coverage: %0d writes, %0d reads served, %0d reads refused.",
                 sb.writes_sent, sb.reads_served, sb.reads_failed);
        $display("Checked %0d response beats, %0d failures.", sb.beats_seen, sb.failures);
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
